// ===== rtl/core/sf_pkg.sv =====
// Shared types and widths for the spring force core.
// Used by every module under rtl/core; no dependencies of its own.
package sf_pkg;

	// Datapath widths, fixed by the Q16.16 formats of the ports.
	localparam int unsigned CoordW = 32;
	localparam int unsigned MagW   = 33;
	localparam int unsigned SqW    = 65;
	localparam int unsigned SumW   = 66;
	localparam int unsigned LenW   = 35;
	localparam int unsigned TrialW = 72;
	localparam int unsigned EkW    = 67;
	localparam int unsigned NumW   = 100;
	localparam int unsigned DenW   = 51;
	localparam int unsigned QW     = 32;
	localparam int unsigned Lanes  = 3;

	// Configuration register indexes.
	localparam logic REG_SPRING_CONSTANT = 1'b0;
	localparam logic REG_REST_LENGTH     = 1'b1;

	// One classified item: per-axis magnitude and sign of d = pos - end.
	typedef struct packed {
		logic [Lanes-1:0]           neg;
		logic [Lanes-1:0][MagW-1:0] mag;
	} sf_item_t;

endpackage

// ===== rtl/core/sf_front.sv =====
// Front end: accepts position items and classifies each axis of d = pos - end.
// Depends on sf_pkg for the item type.
module sf_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [191:0]       in_data,
	output logic               item_valid,
	input  logic               item_ready,
	output sf_pkg::sf_item_t   item
);

	logic             valid_q;
	sf_pkg::sf_item_t item_q;
	sf_pkg::sf_item_t item_d;

	// Difference, magnitude and sign for each axis.
	always_comb begin
		logic signed [sf_pkg::MagW-1:0] d;
		logic [sf_pkg::CoordW-1:0]      p;
		logic [sf_pkg::CoordW-1:0]      e;
		item_d = '0;
		for (int i = 0; i < 3; i++) begin
			p = in_data[i*32 +: 32];
			e = in_data[(i+3)*32 +: 32];
			d = $signed({p[31], p}) - $signed({e[31], e});
			item_d.neg[i] = d[sf_pkg::MagW-1];
			item_d.mag[i] = d[sf_pkg::MagW-1] ? sf_pkg::MagW'(-d) : sf_pkg::MagW'(d);
		end
	end

	assign in_ready   = !valid_q || item_ready;
	assign item_valid = valid_q;
	assign item       = item_q;

	// Holding register between the input port and the queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_q <= item_d;
		end
	end

endmodule

// ===== rtl/core/sf_queue.sv =====
// Small FIFO between the front end and the force pipeline.
// Depends on sf_pkg for the item type.
module sf_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  sf_pkg::sf_item_t push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output sf_pkg::sf_item_t pop_data
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	sf_pkg::sf_item_t mem_q [DEPTH];
	logic [AW-1:0]    wr_ptr_q;
	logic [AW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             push;
	logic             pop;

	assign push_ready = (count_q != CW'(DEPTH));
	assign pop_valid  = (count_q != '0);
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;
	assign pop_data   = mem_q[rd_ptr_q];

	// Pointer and fill count bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

`ifndef ASSERT_OFF
	// The fill count follows the transfers on both sides.
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> count_q == $past(count_q) + CW'($past(push)) - CW'($past(pop)))
		else $error("queue count out of step with transfers");

	// A partly filled queue never has coinciding pointers.
	a_ptrs: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q != '0 && count_q != CW'(DEPTH)) |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers collide");

	// The head entry is not overwritten while it waits.
	a_head: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && !pop_ready) |=> $stable(pop_data))
		else $error("queue head changed while stalled");
`endif

endmodule

// ===== rtl/core/sf_back.sv =====
// Force pipeline: length by square root, extension, scaling and division.
// Depends on sf_pkg for widths and the item type.
module sf_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  sf_pkg::sf_item_t item,
	input  logic [31:0]      spring_constant,
	input  logic [31:0]      rest_length,
	output logic             out_valid,
	input  logic             out_ready,
	output logic [95:0]      out_data,
	output logic             out_clipped
);

	localparam int unsigned SqSteps  = sf_pkg::LenW;
	localparam int unsigned DivSteps = sf_pkg::QW;

	logic en;
	assign en         = !out_valid || out_ready;
	assign item_ready = en;

	// Stage 1: squares of the magnitudes.
	logic                        v_s1;
	sf_pkg::sf_item_t            it_s1;
	logic [sf_pkg::SqW-1:0]      sq_s1 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s1 <= item;
			for (int i = 0; i < 3; i++) begin
				sq_s1[i] <= sf_pkg::SqW'(item.mag[i] * item.mag[i]);
			end
		end
	end

	// Square root pipeline, one result bit per stage. Index 0 holds the sum.
	logic                    sr_v   [SqSteps+1];
	sf_pkg::sf_item_t        sr_it  [SqSteps+1];
	logic [sf_pkg::SumW-1:0] sr_rem [SqSteps+1];
	logic [sf_pkg::LenW-1:0] sr_res [SqSteps+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_v[0] <= 1'b0;
		end else if (en) begin
			sr_v[0] <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sr_it[0]  <= it_s1;
			sr_rem[0] <= sf_pkg::SumW'(sq_s1[0]) + sf_pkg::SumW'(sq_s1[1])
				+ sf_pkg::SumW'(sq_s1[2]);
			sr_res[0] <= '0;
		end
	end

	for (genvar j = 0; j < SqSteps; j++) begin : g_sqrt
		localparam int unsigned B = SqSteps - 1 - j;
		logic [sf_pkg::TrialW-1:0] trial;
		logic                      take;

		// Trial (2*res + 2^B) * 2^B against the remaining radicand.
		assign trial = (sf_pkg::TrialW'(sr_res[j]) << (B + 1))
			+ (sf_pkg::TrialW'(1) << (2 * B));
		assign take  = sf_pkg::TrialW'(sr_rem[j]) >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sr_v[j+1] <= 1'b0;
			end else if (en) begin
				sr_v[j+1] <= sr_v[j];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sr_it[j+1] <= sr_it[j];
				if (take) begin
					sr_rem[j+1] <= sf_pkg::SumW'(sf_pkg::TrialW'(sr_rem[j]) - trial);
					sr_res[j+1] <= sr_res[j] | (sf_pkg::LenW'(1) << B);
				end else begin
					sr_rem[j+1] <= sr_rem[j];
					sr_res[j+1] <= sr_res[j];
				end
			end
		end
	end

	// Stage 3: extension e = abs(len - L) and zero-length flag.
	logic                    v_s3;
	sf_pkg::sf_item_t        it_s3;
	logic [sf_pkg::LenW-1:0] len_s3;
	logic [sf_pkg::LenW-1:0] e_s3;
	logic                    zero_s3;
	logic [sf_pkg::LenW-1:0] len_in;
	logic [sf_pkg::LenW-1:0] rest_ext;

	assign len_in   = sr_res[SqSteps];
	assign rest_ext = sf_pkg::LenW'(rest_length);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sr_v[SqSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s3   <= sr_it[SqSteps];
			len_s3  <= len_in;
			zero_s3 <= (len_in == '0);
			e_s3    <= (len_in >= rest_ext) ? len_in - rest_ext : rest_ext - len_in;
		end
	end

	// Stage 4: e * k.
	logic                    v_s4;
	sf_pkg::sf_item_t        it_s4;
	logic [sf_pkg::LenW-1:0] len_s4;
	logic                    zero_s4;
	logic [sf_pkg::EkW-1:0]  ek_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s4   <= it_s3;
			len_s4  <= len_s3;
			zero_s4 <= zero_s3;
			ek_s4   <= sf_pkg::EkW'(e_s3 * spring_constant);
		end
	end

	// Stage 5: partial products of |d_i| * e * k, split at bit 34.
	logic                    v_s5;
	sf_pkg::sf_item_t        it_s5;
	logic [sf_pkg::LenW-1:0] len_s5;
	logic                    zero_s5;
	logic [66:0]             pp0_s5 [3];
	logic [65:0]             pp1_s5 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s5   <= it_s4;
			len_s5  <= len_s4;
			zero_s5 <= zero_s4;
			for (int i = 0; i < 3; i++) begin
				pp0_s5[i] <= 67'(it_s4.mag[i] * ek_s4[33:0]);
				pp1_s5[i] <= 66'(it_s4.mag[i] * ek_s4[66:34]);
			end
		end
	end

	// Stage 6: full numerators and the divisor len * 2^16.
	logic                    v_s6;
	sf_pkg::sf_item_t        it_s6;
	logic [sf_pkg::DenW-1:0] den_s6;
	logic                    zero_s6;
	logic [sf_pkg::NumW-1:0] num_s6 [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			it_s6   <= it_s5;
			den_s6  <= {len_s5, 16'b0};
			zero_s6 <= zero_s5;
			for (int i = 0; i < 3; i++) begin
				num_s6[i] <= {pp1_s5[i], 34'b0} + sf_pkg::NumW'(pp0_s5[i]);
			end
		end
	end

	// Division pipeline, one quotient bit per stage. Index 0 is the setup stage
	// that flags quotients of 2^32 or more and loads the upper remainder.
	logic                    dv_v    [DivSteps+1];
	logic [2:0]              dv_neg  [DivSteps+1];
	logic                    dv_zero [DivSteps+1];
	logic [sf_pkg::DenW-1:0] dv_den  [DivSteps+1];
	logic [2:0]              dv_ovf  [DivSteps+1];
	logic [sf_pkg::DenW-1:0] dv_rem  [DivSteps+1][3];
	logic [sf_pkg::QW-1:0]   dv_low  [DivSteps+1][3];
	logic [sf_pkg::QW-1:0]   dv_q    [DivSteps+1][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v[0] <= 1'b0;
		end else if (en) begin
			dv_v[0] <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_neg[0]  <= it_s6.neg;
			dv_zero[0] <= zero_s6;
			dv_den[0]  <= den_s6;
			for (int i = 0; i < 3; i++) begin
				dv_ovf[0][i] <= num_s6[i] >= sf_pkg::NumW'({den_s6, 32'b0});
				dv_rem[0][i] <= num_s6[i][32 +: sf_pkg::DenW];
				dv_low[0][i] <= num_s6[i][31:0];
				dv_q[0][i]   <= '0;
			end
		end
	end

	for (genvar j = 0; j < DivSteps; j++) begin : g_div
		localparam int unsigned QB = DivSteps - 1 - j;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_v[j+1] <= 1'b0;
			end else if (en) begin
				dv_v[j+1] <= dv_v[j];
			end
		end

		always_ff @(posedge clk) begin
			logic [sf_pkg::DenW:0] r2;
			if (en) begin
				dv_neg[j+1]  <= dv_neg[j];
				dv_zero[j+1] <= dv_zero[j];
				dv_den[j+1]  <= dv_den[j];
				dv_ovf[j+1]  <= dv_ovf[j];
				for (int i = 0; i < 3; i++) begin
					r2 = {dv_rem[j][i], dv_low[j][i][QB]};
					dv_low[j+1][i] <= dv_low[j][i];
					if (r2 >= {1'b0, dv_den[j]}) begin
						dv_rem[j+1][i] <= sf_pkg::DenW'(r2 - {1'b0, dv_den[j]});
						dv_q[j+1][i]   <= dv_q[j][i] | (sf_pkg::QW'(1) << QB);
					end else begin
						dv_rem[j+1][i] <= sf_pkg::DenW'(r2);
						dv_q[j+1][i]   <= dv_q[j][i];
					end
				end
			end
		end
	end

	// Sign, saturation and the zero-length case.
	logic [95:0] force_d;
	logic        clip_d;

	always_comb begin
		logic [sf_pkg::QW-1:0] q;
		logic                  sat;
		force_d = '0;
		clip_d  = 1'b0;
		for (int i = 0; i < 3; i++) begin
			q = dv_q[DivSteps][i];
			if (!dv_neg[DivSteps][i]) begin
				sat = dv_ovf[DivSteps][i] || (q > 32'h8000_0000);
				force_d[i*32 +: 32] = sat ? 32'h8000_0000 : 32'(-q);
			end else begin
				sat = dv_ovf[DivSteps][i] || q[31];
				force_d[i*32 +: 32] = sat ? 32'h7FFF_FFFF : q;
			end
			clip_d = clip_d || sat;
		end
		if (dv_zero[DivSteps]) begin
			force_d = '0;
			clip_d  = 1'b0;
		end
	end

	// Output register; the whole pipeline holds while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dv_v[DivSteps];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data    <= force_d;
			out_clipped <= clip_d;
		end
	end

endmodule

// ===== rtl/core/spring_force_core.sv =====
// Spring force core: F = -(d/|d|) * k * abs(|d| - L), signed Q16.16, saturated.
// Throughput one item per cycle; the 35-stage square root and 32-stage divider
// are fully pipelined and all stages advance together unless the output stalls.
// Reset (arst_n low) empties the pipeline and queue, sets k to 1.0 and L to 0.
// Depends on sf_pkg, sf_front, sf_queue and sf_back.
module spring_force_core #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic         clk,
	input  logic         arst_n,
	// s_tdata: pos_x, pos_y, pos_z, end_x, end_y, end_z (32 bits each)
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [191:0] s_tdata,
	// m_tdata: force_x, force_y, force_z (32 bits each); m_tuser: clipped
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [95:0]  m_tdata,
	output logic         m_tuser,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	logic             fr_valid;
	logic             fr_ready;
	sf_pkg::sf_item_t fr_item;
	logic             bk_valid;
	logic             bk_ready;
	sf_pkg::sf_item_t bk_item;
	logic [31:0]      spring_constant_q;
	logic [31:0]      rest_length_q;
	logic             reg_sel;

	// Configuration registers on the APB port.
	assign pready  = 1'b1;
	assign reg_sel = paddr[2];
	assign prdata  = (reg_sel == sf_pkg::REG_REST_LENGTH) ? rest_length_q : spring_constant_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spring_constant_q <= 32'h0001_0000;
			rest_length_q     <= '0;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_sel)
				sf_pkg::REG_SPRING_CONSTANT: spring_constant_q <= pwdata;
				sf_pkg::REG_REST_LENGTH:     rest_length_q     <= pwdata;
				default: ;
			endcase
		end
	end

	sf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.in_data    (s_tdata),
		.item_valid (fr_valid),
		.item_ready (fr_ready),
		.item       (fr_item)
	);

	sf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (fr_valid),
		.push_ready (fr_ready),
		.push_data  (fr_item),
		.pop_valid  (bk_valid),
		.pop_ready  (bk_ready),
		.pop_data   (bk_item)
	);

	sf_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.item_valid      (bk_valid),
		.item_ready      (bk_ready),
		.item            (bk_item),
		.spring_constant (spring_constant_q),
		.rest_length     (rest_length_q),
		.out_valid       (m_tvalid),
		.out_ready       (m_tready),
		.out_data        (m_tdata),
		.out_clipped     (m_tuser)
	);

endmodule

// ===== tb/tb_top.sv =====
// Self-checking testbench for spring_force_core: streams position pairs, predicts each
// saturated Q16.16 spring force bit for bit and checks it against the output stream.
// Depends on sf_pkg and the spring_force_core RTL.
module tb_top;

	typedef struct {
		logic [31:0] fx;
		logic [31:0] fy;
		logic [31:0] fz;
		logic        clip;
	} force_t;

	logic         clk;
	logic         arst_n;
	logic         s_tvalid;
	logic         s_tready;
	// s_tdata: pos_x, pos_y, pos_z, end_x, end_y, end_z (32 bits each)
	logic [191:0] s_tdata;
	logic         m_tvalid;
	logic         m_tready;
	// m_tdata: force_x, force_y, force_z (32 bits each); m_tuser: clipped
	logic [95:0]  m_tdata;
	logic         m_tuser;
	logic         psel;
	logic         penable;
	logic         pwrite;
	logic [2:0]   paddr;
	logic [31:0]  pwdata;
	logic [31:0]  prdata;
	logic         pready;

	logic [191:0] pending_items[$];
	force_t       expected_forces[$];
	logic [31:0]  stiffness;
	logic [31:0]  rest_len;
	int           errors;
	bit           send_burst;
	bit           recv_burst;
	bit           s_took;
	bit           m_took;
	int           send_gap;
	int           recv_gap;
	int           hold_cnt;
	int           forces_seen;
	bit           hold_done;

	spring_force_core dut (.*);

	// Clock and run timeout; the one reset comes from the main initial block.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#(20 * 2000000);
		$display("tb_top NOT OK");
		$finish;
	end

	// Exact force of one item under the given stiffness and rest length.
	function automatic force_t spring_predict(logic [191:0] item, logic [31:0] k,
			logic [31:0] rl);
		force_t         r;
		logic [32:0]    mag[3];
		bit             neg[3];
		logic [127:0]   sumsq;
		logic [127:0]   cand;
		logic [127:0]   num;
		logic [127:0]   quo;
		logic [63:0]    len;
		logic [63:0]    ext;
		longint signed  dv;
		logic [31:0]    f[3];
		r = '{0, 0, 0, 1'b0};
		sumsq = '0;
		for (int i = 0; i < 3; i++) begin
			dv = longint'($signed(item[32*i +: 32])) - longint'($signed(item[32*(i+3) +: 32]));
			neg[i] = dv < 0;
			mag[i] = neg[i] ? 33'(-dv) : 33'(dv);
			sumsq += 128'(mag[i]) * 128'(mag[i]);
		end
		len = '0;
		for (int b = 34; b >= 0; b--) begin
			cand = 128'(len) | (128'(1) << b);
			if (cand * cand <= sumsq)
				len = cand[63:0];
		end
		if (len == 0)
			return r;
		ext = (len >= 64'(rl)) ? len - 64'(rl) : 64'(rl) - len;
		for (int i = 0; i < 3; i++) begin
			num = 128'(ext) * 128'(k) * 128'(mag[i]);
			quo = num / (128'(len) << 16);
			if (!neg[i]) begin
				if (quo > 128'h8000_0000) begin
					f[i] = 32'h8000_0000;
					r.clip = 1'b1;
				end else begin
					f[i] = -quo[31:0];
				end
			end else if (quo > 128'h7FFF_FFFF) begin
				f[i] = 32'h7FFF_FFFF;
				r.clip = 1'b1;
			end else begin
				f[i] = quo[31:0];
			end
		end
		r.fx = f[0];
		r.fy = f[1];
		r.fz = f[2];
		return r;
	endfunction

	// Input driver: one item per transfer, random gap drawn per item outside send bursts.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_tvalid || s_took) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (pending_items.size() != 0) begin
					s_tdata  <= pending_items.pop_front();
					s_tvalid <= 1'b1;
					send_gap <= send_burst ? 0 : $urandom_range(0, 8);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// Output receiver: random stall per result outside receive bursts, plus one long hold-off.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && forces_seen >= 100) begin
				hold_done <= 1'b1;
				hold_cnt  <= 400;
				m_tready  <= 1'b0;
			end else if (hold_cnt > 0) begin
				hold_cnt <= hold_cnt - 1;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else if (m_took && !recv_burst) begin
				recv_gap <= $urandom_range(0, 8);
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Monitor: register writes, accepted items and checked results.
	always @(posedge clk) begin
		force_t exp_f;
		s_took <= s_tvalid && s_tready;
		m_took <= m_tvalid && m_tready;
		if (psel && penable && pwrite && pready) begin
			if (paddr[2] == sf_pkg::REG_SPRING_CONSTANT)
				stiffness <= pwdata;
			else
				rest_len <= pwdata;
		end
		if (s_tvalid && s_tready)
			expected_forces.push_back(spring_predict(s_tdata, stiffness, rest_len));
		if (m_tvalid && m_tready) begin
			forces_seen <= forces_seen + 1;
			if (expected_forces.size() == 0) begin
				$display("%0t: unexpected result %h clip %b", $time, m_tdata, m_tuser);
				errors++;
			end else begin
				exp_f = expected_forces.pop_front();
				if (m_tdata[31:0] !== exp_f.fx) begin
					$display("%0t: force_x expected %h actual %h", $time, exp_f.fx,
						m_tdata[31:0]);
					errors++;
				end
				if (m_tdata[63:32] !== exp_f.fy) begin
					$display("%0t: force_y expected %h actual %h", $time, exp_f.fy,
						m_tdata[63:32]);
					errors++;
				end
				if (m_tdata[95:64] !== exp_f.fz) begin
					$display("%0t: force_z expected %h actual %h", $time, exp_f.fz,
						m_tdata[95:64]);
					errors++;
				end
				if (m_tuser !== exp_f.clip) begin
					$display("%0t: clipped expected %b actual %b", $time, exp_f.clip,
						m_tuser);
					errors++;
				end
			end
		end
	end

	// Register write on the configuration port: a setup phase, then an access phase.
	task automatic reg_write(logic idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Block the stimulus until the block has drained completely.
	task automatic wait_drained();
		while (pending_items.size() != 0 || expected_forces.size() != 0 || s_tvalid)
			@(posedge clk);
		repeat (100) @(posedge clk);
	endtask

	function automatic logic [191:0] pack_item(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz, logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
		return {ez, ey, ex, pz, py, px};
	endfunction

	// Mostly near pairs so that forces stay in range; some fully random pairs.
	function automatic logic [191:0] random_item();
		logic [191:0] it;
		int           sh;
		for (int i = 0; i < 6; i++)
			it[32*i +: 32] = $urandom;
		if ($urandom_range(0, 3) != 0) begin
			sh = $urandom_range(0, 31);
			for (int i = 0; i < 3; i++)
				it[32*(i+3) +: 32] = it[32*i +: 32] + ($signed($urandom) >>> sh);
		end
		return it;
	endfunction

	initial begin
		logic [31:0] k_set[5];
		logic [31:0] l_set[5];
		int          ph;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		m_tready   = 1'b0;
		psel       = 1'b0;
		penable    = 1'b0;
		pwrite     = 1'b0;
		paddr      = '0;
		pwdata     = '0;
		stiffness  = 32'h0001_0000;
		rest_len   = '0;
		errors     = 0;
		send_burst = 1'b0;
		recv_burst = 1'b0;
		s_took     = 1'b0;
		m_took     = 1'b0;
		send_gap   = 0;
		recv_gap   = 0;
		hold_cnt   = 0;
		forces_seen = 0;
		hold_done  = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: zero length, extreme separations, overflow.
		pending_items.push_back(pack_item(0, 0, 0, 0, 0, 0));
		pending_items.push_back(pack_item(32'h7FFF_FFFF, 32'h8000_0000, 5,
			32'h7FFF_FFFF, 32'h8000_0000, 5));
		pending_items.push_back(pack_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
		pending_items.push_back(pack_item(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0));
		pending_items.push_back(pack_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000));
		pending_items.push_back(pack_item(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF));
		pending_items.push_back(pack_item(32'h0001_0000, 0, 0, 0, 0, 0));
		pending_items.push_back(pack_item(0, 32'hFFFF_0000, 0, 0, 0, 0));
		pending_items.push_back(pack_item(1, 1, 1, 0, 0, 0));
		pending_items.push_back(pack_item(32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0));
		wait_drained();
		// Compressed spring and the largest stiffness.
		reg_write(sf_pkg::REG_REST_LENGTH, 32'h000A_0000);
		reg_write(sf_pkg::REG_SPRING_CONSTANT, 32'hFFFF_FFFF);
		wait_drained();
		pending_items.push_back(pack_item(32'h0001_0000, 0, 0, 0, 0, 0));
		pending_items.push_back(pack_item(0, 0, 32'hFFFF_0000, 0, 0, 0));
		pending_items.push_back(pack_item(32'h000A_0000, 0, 0, 0, 0, 0));
		pending_items.push_back(pack_item(32'h7FFF_FFFF, 0, 0, 32'h8000_0000, 0, 0));
		pending_items.push_back(pack_item(1, 0, 0, 0, 0, 0));
		pending_items.push_back(pack_item(0, 0, 0, 0, 0, 0));
		wait_drained();

		// Random phases over several register settings, extremes included.
		k_set = '{32'h0001_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, $urandom};
		l_set = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0002_0000, $urandom};
		for (ph = 0; ph < 5; ph++) begin
			reg_write(sf_pkg::REG_SPRING_CONSTANT, k_set[ph]);
			reg_write(sf_pkg::REG_REST_LENGTH, l_set[ph]);
			send_burst = (ph == 0) || (ph == 3);
			recv_burst = (ph == 2) || (ph == 3);
			for (int n = 0; n < 300; n++)
				pending_items.push_back(random_item());
			wait_drained();
		end

		if (errors == 0) begin
			$display("tb_top OK");
		end else begin
			$display("tb_top NOT OK");
		end
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sf_pkg.sv
rtl/core/sf_front.sv
rtl/core/sf_queue.sv
rtl/core/sf_back.sv
rtl/core/spring_force_core.sv
tb/tb_top.sv
